/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the statement splitter checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define QSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("splitter check failed");

// Next-cycle implication, disabled while reset is low.
`define QSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("splitter check failed");

`endif

/* rtl/core/qss_pkg.sv */
// ---------------------------------------------------------------------------
// qss_pkg
// Types and constants of the quoted statement splitter.
// ---------------------------------------------------------------------------
package qss_pkg;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    localparam logic [1:0] KIND_SQL  = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_ARGS = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic CMD_SQL       = 1'b0;
    localparam logic CMD_BACKSLASH = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_NAME  = 2'd1;
    localparam logic [1:0] ST_UNTERM   = 2'd2;
    localparam logic [1:0] ST_CLEAN    = 2'd3;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } t_quote;

    typedef enum logic [2:0] {
        PH_LEAD      = 3'd0,
        PH_SQL       = 3'd1,
        PH_META_PRE  = 3'd2,
        PH_META_NAME = 3'd3,
        PH_META_POST = 3'd4,
        PH_META_ARGS = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] field_kind;
        logic       cmd_kind;
        logic       stmt_end;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_quote  next_quote;
        t_phase  next_phase;
        t_result res;
    } t_step;

endpackage

/* rtl/core/qss_step.sv */
// ---------------------------------------------------------------------------
// qss_step
// Per-byte decision: next quote/phase state and the optional result beat.
// ---------------------------------------------------------------------------
module qss_step
    import qss_pkg::*;
(
    input  t_quote     i_quote,
    input  t_phase     i_phase,
    input  logic       i_op,
    input  logic [7:0] i_byte,
    output t_step      o_step
);

    t_phase ph;
    t_quote q_trk;
    logic   is_ws;
    logic   cmd;

    assign is_ws = (i_byte == CH_SPACE) || (i_byte inside {[8'd9:8'd13]});

    // Unused phase codes behave as leading whitespace.
    always_comb begin
        case (i_phase)
            PH_LEAD, PH_SQL, PH_META_PRE,
            PH_META_NAME, PH_META_POST, PH_META_ARGS: ph = i_phase;
            default: ph = PH_LEAD;
        endcase
    end

    assign cmd = (ph == PH_LEAD || ph == PH_SQL) ? CMD_SQL : CMD_BACKSLASH;

    // Open on either quote outside quotes; close only on the matching kind.
    always_comb begin
        q_trk = i_quote;
        case (i_quote)
            Q_NONE: begin
                if (i_byte == CH_SQUOTE) q_trk = Q_SINGLE;
                else if (i_byte == CH_DQUOTE) q_trk = Q_DOUBLE;
            end
            Q_SINGLE: if (i_byte == CH_SQUOTE) q_trk = Q_NONE;
            Q_DOUBLE: if (i_byte == CH_DQUOTE) q_trk = Q_NONE;
            default: q_trk = i_quote;
        endcase
    end

    always_comb begin
        o_step                = '0;
        o_step.next_quote     = i_quote;
        o_step.next_phase     = ph;
        o_step.res.out_byte   = i_byte;
        o_step.res.cmd_kind   = cmd;
        o_step.res.stmt_end   = 1'b0;
        o_step.res.status     = ST_OK;
        o_step.res.field_kind = KIND_SQL;
        if (i_op == OP_EOS) begin
            o_step.emit           = 1'b1;
            o_step.next_quote     = Q_NONE;
            o_step.next_phase     = PH_LEAD;
            o_step.res.out_byte   = '0;
            o_step.res.field_kind = KIND_NONE;
            o_step.res.stmt_end   = 1'b1;
            if (ph == PH_LEAD && i_quote == Q_NONE) begin
                o_step.res.status   = ST_CLEAN;
                o_step.res.cmd_kind = CMD_SQL;
            end else begin
                o_step.res.status   = ST_UNTERM;
            end
        end else if (i_quote == Q_NONE && i_byte == CH_SEMI) begin
            o_step.emit           = 1'b1;
            o_step.next_phase     = PH_LEAD;
            o_step.res.out_byte   = '0;
            o_step.res.field_kind = KIND_NONE;
            o_step.res.stmt_end   = 1'b1;
            o_step.res.status     = (ph == PH_META_PRE) ? ST_NO_NAME : ST_OK;
        end else begin
            case (ph)
                PH_LEAD: begin
                    if (i_byte == CH_BSLASH) begin
                        o_step.next_phase = PH_META_PRE;
                    end else if (!is_ws) begin
                        o_step.emit       = 1'b1;
                        o_step.next_quote = q_trk;
                        o_step.next_phase = PH_SQL;
                    end
                end
                PH_SQL: begin
                    o_step.emit       = 1'b1;
                    o_step.next_quote = q_trk;
                end
                PH_META_PRE: begin
                    if (!is_ws) begin
                        o_step.emit           = 1'b1;
                        o_step.next_quote     = q_trk;
                        o_step.next_phase     = PH_META_NAME;
                        o_step.res.field_kind = KIND_NAME;
                    end
                end
                PH_META_NAME: begin
                    o_step.next_quote     = q_trk;
                    o_step.res.field_kind = KIND_NAME;
                    if (is_ws) o_step.next_phase = PH_META_POST;
                    else o_step.emit = 1'b1;
                end
                PH_META_POST: begin
                    o_step.res.field_kind = KIND_ARGS;
                    if (!is_ws) begin
                        o_step.emit       = 1'b1;
                        o_step.next_quote = q_trk;
                        o_step.next_phase = PH_META_ARGS;
                    end
                end
                default: begin
                    o_step.emit           = 1'b1;
                    o_step.next_quote     = q_trk;
                    o_step.res.field_kind = KIND_ARGS;
                end
            endcase
        end
    end

endmodule

/* rtl/core/quoted_statement_splitter.sv */
// ---------------------------------------------------------------------------
// quoted_statement_splitter
// Splits a text byte stream into SQL and meta commands at unquoted semicolons.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata            | tuser                            | tlast
//  ---------+-----+------------------+----------------------------------+---------
//  s_axis   | in  | [7:0] in_byte    | [0] op (0 byte, 1 end of stream)  | -
//  m_axis   | out | [7:0] out_byte   | [1:0] field_kind [2] cmd_kind     | stmt_end
//           |     |                  | [4:3] status                      |
//
//  One beat per cycle sustained while the output keeps up. A beat goes from the
//  input register through the combinational step logic into the output register.
//  A beat that yields no result (dropped whitespace, backslash) is simply
//  consumed. When the output register is full and not taken, the input
//  register holds; s_axis_tready falls only then. Reset (synchronous, active
//  low) empties both registers and returns to outside quotes, leading blanks.
//
module quoted_statement_splitter
    import qss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] op

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [4:0] m_axis_tuser,   // [1:0] field_kind, [2] cmd_kind, [4:3] status
    output logic       m_axis_tlast    // stmt_end
);

    // Input register
    logic       r_iv;
    logic       r_op;
    logic [7:0] r_byte;

    // Statement state
    t_quote r_quote, n_quote;
    t_phase r_phase, n_phase;

    // Output register
    logic    r_ov,  n_ov;
    t_result r_res;

    t_step step;
    logic  out_free;
    logic  advance;

    assign out_free      = !r_ov || m_axis_tready;
    assign advance       = r_iv && out_free;
    assign s_axis_tready = !r_iv || out_free;

    qss_step u_step (
        .i_quote (r_quote),
        .i_phase (r_phase),
        .i_op    (r_op),
        .i_byte  (r_byte),
        .o_step  (step)
    );

    // Commit the step only when the beat moves out of the input register.
    always_comb begin
        n_quote = r_quote;
        n_phase = r_phase;
        n_ov    = r_ov && !m_axis_tready;
        if (advance) begin
            n_quote = step.next_quote;
            n_phase = step.next_phase;
            if (step.emit) n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv    <= 1'b0;
            r_ov    <= 1'b0;
            r_quote <= Q_NONE;
            r_phase <= PH_LEAD;
        end else begin
            r_ov    <= n_ov;
            r_quote <= n_quote;
            r_phase <= n_phase;
            if (s_axis_tready) r_iv <= s_axis_tvalid;
        end
    end

    // Payload: load on accept, no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_op   <= s_axis_tuser;
            r_byte <= s_axis_tdata;
        end
        if (advance && step.emit) r_res <= step.res;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_res.out_byte;
    assign m_axis_tuser  = {r_res.status, r_res.cmd_kind, r_res.field_kind};
    assign m_axis_tlast  = r_res.stmt_end;

endmodule

/* rtl/core/qss_checker.sv */
// ---------------------------------------------------------------------------
// qss_checker
// Port-level checks of the statement splitter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qss_checker
    import qss_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [4:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    logic stall;
    logic marker;

    assign stall  = m_axis_tvalid && !m_axis_tready;
    assign marker = m_axis_tuser[1:0] == KIND_NONE;

    // Stalled result beat holds its payload.
    `QSS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stall,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Input backs off only behind a stalled result beat.
    `QSS_ASSERT_IMPLY(a_in_stall, i_clk, i_rst_n, !s_axis_tready, stall)

    // End markers and only end markers have kind none, and markers carry a zero byte.
    `QSS_ASSERT_IMPLY(a_marker, i_clk, i_rst_n, m_axis_tvalid,
        (marker == m_axis_tlast) && (!marker || m_axis_tdata == 8'd0))

    // Byte beats always report ok status.
    `QSS_ASSERT_IMPLY(a_byte_ok, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast,
        m_axis_tuser[4:3] == ST_OK)

    // Clean end of stream is reported as an sql statement.
    `QSS_ASSERT_IMPLY(a_clean_sql, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[4:3] == ST_CLEAN, m_axis_tuser[2] == CMD_SQL)

endmodule

bind quoted_statement_splitter qss_checker u_qss_checker (.*);

/* tb/tb_quoted_statement_splitter.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_quoted_statement_splitter
// Drives byte and end-of-stream beats into the splitter, takes each expected
// beat from the directed table or a behavioral copy of the rules; checks field by field.
// ---------------------------------------------------------------------------
module tb_quoted_statement_splitter;
    import qss_pkg::*;

    localparam int IDLE_PCT      = 14;      // chance of an idle cycle on each side
    localparam int HOLD_CYCLES   = 80;      // long receiver hold-off
    localparam int CALM_BEATS    = 200;     // beats sent with no random idling on either side
    localparam int RANDOM_ITEMS  = 850;
    localparam int DRAIN_CYCLES  = 10;      // input and output register plus margin
    localparam int CYCLE_LIMIT   = 100000;
    localparam int REPORT_LIMIT  = 10;

    // One row of directed stimulus. want is only meaningful when typed is set.
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       typed;
        t_result    want;
    } t_row;

    localparam t_result NO_RESULT = '0;
    localparam int      DIRECTED_ROWS = 28;

    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // end of stream right after reset: clean end
        '{OP_EOS,  8'hA5,     1'b1, '{8'h00, KIND_NONE, CMD_SQL, 1'b1, ST_CLEAN}},
        // bare semicolon: empty sql statement
        '{OP_DATA, CH_SEMI,   1'b1, '{8'h00, KIND_NONE, CMD_SQL, 1'b1, ST_OK}},
        // backslash then semicolon: meta command without a name
        '{OP_DATA, CH_BSLASH, 1'b0, NO_RESULT},
        '{OP_DATA, CH_SEMI,   1'b1, '{8'h00, KIND_NONE, CMD_BACKSLASH, 1'b1, ST_NO_NAME}},
        // leading blank, blank after backslash, name, blank, args
        '{OP_DATA, 8'h09,     1'b0, NO_RESULT},
        '{OP_DATA, CH_BSLASH, 1'b0, NO_RESULT},
        '{OP_DATA, CH_SPACE,  1'b0, NO_RESULT},
        '{OP_DATA, 8'h64,     1'b0, NO_RESULT},
        '{OP_DATA, 8'h0B,     1'b0, NO_RESULT},
        '{OP_DATA, 8'hFF,     1'b0, NO_RESULT},
        '{OP_DATA, 8'h0D,     1'b0, NO_RESULT},
        '{OP_DATA, CH_SEMI,   1'b0, NO_RESULT},
        // sql with a quoted semicolon and a doubled quote left open
        '{OP_DATA, 8'h00,     1'b0, NO_RESULT},
        '{OP_DATA, CH_SQUOTE, 1'b0, NO_RESULT},
        '{OP_DATA, CH_SEMI,   1'b0, NO_RESULT},
        '{OP_DATA, CH_SQUOTE, 1'b0, NO_RESULT},
        '{OP_DATA, CH_SQUOTE, 1'b0, NO_RESULT},
        '{OP_EOS,  8'h5A,     1'b1, '{8'h00, KIND_NONE, CMD_SQL, 1'b1, ST_UNTERM}},
        // single quote inside double quotes does not close, trailing blank kept
        '{OP_DATA, CH_DQUOTE, 1'b0, NO_RESULT},
        '{OP_DATA, CH_SQUOTE, 1'b0, NO_RESULT},
        '{OP_DATA, CH_DQUOTE, 1'b0, NO_RESULT},
        '{OP_DATA, CH_SPACE,  1'b0, NO_RESULT},
        '{OP_DATA, CH_SEMI,   1'b0, NO_RESULT},
        // meta command cut by end of stream
        '{OP_DATA, CH_BSLASH, 1'b0, NO_RESULT},
        '{OP_DATA, 8'h78,     1'b0, NO_RESULT},
        '{OP_EOS,  8'hFF,     1'b1, '{8'h00, KIND_NONE, CMD_BACKSLASH, 1'b1, ST_UNTERM}},
        // whitespace only before end of stream still ends cleanly
        '{OP_DATA, CH_SPACE,  1'b0, NO_RESULT},
        '{OP_EOS,  8'h00,     1'b1, '{8'h00, KIND_NONE, CMD_SQL, 1'b1, ST_CLEAN}}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tuser = 1'b0;    // [0] op
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [4:0] m_axis_tuser;           // [1:0] field_kind, [2] cmd_kind, [4:3] status
    logic       m_axis_tlast;           // stmt_end

    // Splitter state as the predictor sees it.
    t_quote  quote_st = Q_NONE;
    t_phase  phase_st = PH_LEAD;

    // Output beats still owed by the block, oldest first.
    t_result statement_pieces [$];

    int      sent_beats = 0;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      calm = 1'b0;       // suppress idling on both sides
    bit      hold_req = 1'b0;   // ask the receiver for a long hold-off
    int      hold_cnt;
    t_result seen_piece;
    t_result due_piece;

    quoted_statement_splitter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: end the run if the stream stalls or the drain never finishes.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Quotes only open from outside; only the same kind closes them.
    function automatic void note_quote(input logic [7:0] c);
        if (quote_st == Q_NONE) begin
            if (c == CH_SQUOTE)
                quote_st = Q_SINGLE;
            else if (c == CH_DQUOTE)
                quote_st = Q_DOUBLE;
        end else if ((quote_st == Q_SINGLE && c == CH_SQUOTE) ||
                     (quote_st == Q_DOUBLE && c == CH_DQUOTE)) begin
            quote_st = Q_NONE;
        end
    endfunction

    // Advance the splitter state by one accepted beat. Returns 1 when the beat
    // produces an output beat, which is then left in piece.
    function automatic logic split_byte(input logic op, input logic [7:0] c,
                                        output t_result piece);
        t_phase ph;
        logic   emit;
        ph = phase_st;
        emit = 1'b1;
        // End markers by default; byte beats overwrite below.
        piece.out_byte   = 8'h00;
        piece.field_kind = KIND_NONE;
        piece.cmd_kind   = (ph >= PH_META_PRE) ? CMD_BACKSLASH : CMD_SQL;
        piece.stmt_end   = 1'b1;
        piece.status     = ST_OK;

        if (op == OP_EOS) begin
            // Anything but blanks outside quotes means an unterminated statement.
            if (ph == PH_LEAD && quote_st == Q_NONE) begin
                piece.status   = ST_CLEAN;
                piece.cmd_kind = CMD_SQL;
            end else begin
                piece.status = ST_UNTERM;
            end
            quote_st = Q_NONE;
            phase_st = PH_LEAD;
            return 1'b1;
        end

        if (quote_st == Q_NONE && c == CH_SEMI) begin
            piece.status = (ph == PH_META_PRE) ? ST_NO_NAME : ST_OK;
            phase_st = PH_LEAD;
            return 1'b1;
        end

        piece.out_byte = c;
        piece.stmt_end = 1'b0;
        case (ph)
            PH_LEAD: begin
                if (is_blank(c)) begin
                    emit = 1'b0;
                end else if (c == CH_BSLASH) begin
                    phase_st = PH_META_PRE;
                    emit = 1'b0;
                end else begin
                    note_quote(c);
                    phase_st = PH_SQL;
                    piece.field_kind = KIND_SQL;
                end
            end
            PH_SQL: begin
                note_quote(c);
                piece.field_kind = KIND_SQL;
            end
            PH_META_PRE: begin
                if (is_blank(c)) begin
                    emit = 1'b0;
                end else begin
                    note_quote(c);
                    phase_st = PH_META_NAME;
                    piece.field_kind = KIND_NAME;
                end
            end
            PH_META_NAME: begin
                note_quote(c);
                if (is_blank(c)) begin
                    phase_st = PH_META_POST;
                    emit = 1'b0;
                end else begin
                    piece.field_kind = KIND_NAME;
                end
            end
            PH_META_POST: begin
                if (is_blank(c)) begin
                    emit = 1'b0;
                end else begin
                    note_quote(c);
                    phase_st = PH_META_ARGS;
                    piece.field_kind = KIND_ARGS;
                end
            end
            default: begin
                note_quote(c);
                piece.field_kind = KIND_ARGS;
            end
        endcase
        piece.cmd_kind = (piece.field_kind == KIND_SQL) ? CMD_SQL : CMD_BACKSLASH;
        return emit;
    endfunction

    // Offer one beat, idling at random first, and hold it until it is taken.
    // The prediction is made at the edge that accepts the beat.
    task automatic offer(input logic op, input logic [7:0] data,
                         input logic typed, input t_result want);
        t_result piece;
        logic    hit;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        hit = split_byte(op, data, piece);
        if (typed)
            statement_pieces.push_back(want);
        else if (hit)
            statement_pieces.push_back(piece);
        sent_beats++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        offer(OP_DATA, data, 1'b0, NO_RESULT);
    endtask

    function automatic logic [7:0] blank_byte();
        int pick;
        pick = $urandom_range(9, 14);
        return (pick == 14) ? CH_SPACE : 8'(pick);
    endfunction

    // Text biased toward the bytes the splitter cares about, with a share of
    // arbitrary bytes so every bit toggles.
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            return 8'(8'h61 + $urandom_range(25));
        else if (pick < 50)
            return blank_byte();
        else if (pick < 55)
            return CH_BSLASH;
        else if (pick < 60)
            return CH_SEMI;
        else if (pick < 63)
            return $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
        else
            return 8'($urandom_range(255));
    endfunction

    // Statement body: plain text with quoted literals that usually close.
    task automatic send_body(input int len);
        logic [7:0] quote_ch;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 12) begin
                quote_ch = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                send_byte(quote_ch);
                repeat ($urandom_range(4)) send_byte(text_byte());
                if ($urandom_range(99) < 85)
                    send_byte(quote_ch);
            end else begin
                send_byte(text_byte());
            end
        end
    endtask

    // One statement: mostly well formed sql or meta, some raw noise.
    task automatic send_statement();
        int ending;
        repeat ($urandom_range(2)) send_byte(blank_byte());
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(255)));
        end else if ($urandom_range(99) < 40) begin
            send_byte(CH_BSLASH);
            repeat ($urandom_range(1)) send_byte(blank_byte());
            // zero name bytes can leave a meta command without a name
            repeat ($urandom_range(4)) begin
                if ($urandom_range(99) < 70)
                    send_byte(8'(8'h61 + $urandom_range(25)));
                else
                    send_byte(text_byte());
            end
            repeat ($urandom_range(2)) send_byte(blank_byte());
            send_body($urandom_range(8));
        end else begin
            send_body($urandom_range(12));
        end
        ending = $urandom_range(99);
        if (ending < 85)
            send_byte(CH_SEMI);
        else if (ending < 93)
            offer(OP_EOS, 8'($urandom_range(255)), 1'b0, NO_RESULT);
        // otherwise run straight into the next statement
    endtask

    // Receiver: random backpressure, calm stretches, and one long hold-off
    // counted here while the sender keeps pushing.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Check every output beat against the oldest predicted piece.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_piece.out_byte   = m_axis_tdata;
            seen_piece.field_kind = m_axis_tuser[1:0];
            seen_piece.cmd_kind   = m_axis_tuser[2];
            seen_piece.stmt_end   = m_axis_tlast;
            seen_piece.status     = m_axis_tuser[4:3];
            if (statement_pieces.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected beat: byte %02h kind %0d cmd %0d end %0d st %0d",
                             seen_piece.out_byte, seen_piece.field_kind,
                             seen_piece.cmd_kind, seen_piece.stmt_end, seen_piece.status);
            end else begin
                due_piece = statement_pieces.pop_front();
                if (seen_piece.out_byte   !== due_piece.out_byte   ||
                    seen_piece.field_kind !== due_piece.field_kind ||
                    seen_piece.cmd_kind   !== due_piece.cmd_kind   ||
                    seen_piece.stmt_end   !== due_piece.stmt_end   ||
                    seen_piece.status     !== due_piece.status) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: got byte %02h kind %0d cmd %0d end %0d st %0d, %s",
                                 seen_piece.out_byte, seen_piece.field_kind,
                                 seen_piece.cmd_kind, seen_piece.stmt_end,
                                 seen_piece.status,
                                 $sformatf("want byte %02h kind %0d cmd %0d end %0d st %0d",
                                           due_piece.out_byte, due_piece.field_kind,
                                           due_piece.cmd_kind, due_piece.stmt_end,
                                           due_piece.status));
                end
            end
        end
    end

    // Sender: reset, directed table, random statements, drain, verdict.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);

        // Open the random part with a burst: receiver holds off, sender never
        // idles, so both registers fill and the input stalls.
        calm = 1'b1;
        hold_req = 1'b1;
        while (sent_beats < DIRECTED_ROWS + RANDOM_ITEMS) begin
            if (sent_beats >= DIRECTED_ROWS + CALM_BEATS)
                calm = 1'b0;
            send_statement();
        end

        s_axis_tvalid <= 1'b0;
        while (statement_pieces.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && statement_pieces.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
